@@ rtl/rgb_max_pool_2x2_assert.svh @@
// Assertion macros for the 2x2 max pooling block.
// Used by rtl modules that carry concurrent checks; expects clk and rst_n in scope.
`ifndef RGB_MAX_POOL_2X2_ASSERT_SVH
`define RGB_MAX_POOL_2X2_ASSERT_SVH

// Check that a condition holds at every clock edge out of reset.
`define RMP_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define RMP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define RMP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/rmp_pkg.sv @@
// Package for the 2x2 max pooling block: payload types, queue op and constants.
// No dependencies; imported by every rtl module of the block.
package rmp_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int LINE_AW    = $clog2(LINE_DEPTH);
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int CFG_W      = 12;
    localparam int QDEPTH     = 4;
    localparam int QAW        = $clog2(QDEPTH);
    localparam int QCW        = $clog2(QDEPTH + 1);

    localparam logic [CFG_W-1:0] WIDTH_RESET = CFG_W'(640);
    localparam logic [CFG_W-1:0] WIDTH_MIN   = CFG_W'(2);
    localparam logic [CFG_W-1:0] WIDTH_MAX   = CFG_W'(MAX_WIDTH);
    localparam logic [7:0]       ALPHA_VALUE = 8'd255;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic       frame_start;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] alpha_out;
    } pixel_out_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    // One line buffer access: store a pair maximum, or read and emit.
    typedef struct packed {
        logic               emit;
        logic [LINE_AW-1:0] idx;
        rgb_t               pm;
    } op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [7:0] chan_max(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic rgb_t rgb_max(input rgb_t a, input rgb_t b);
        rgb_t m;
        m.r = chan_max(a.r, b.r);
        m.g = chan_max(a.g, b.g);
        m.b = chan_max(a.b, b.b);
        return m;
    endfunction

endpackage

@@ rtl/rmp_front.sv @@
// Front end: width register, row/column tracking and pair maximum.
// Depends on rmp_pkg; issues line buffer ops into rmp_queue.
module rmp_front
    import rmp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  pixel_in_t        in_data,
    input  q_status_t        q_status,
    output logic             push,
    output op_t              push_op
);

    logic [CFG_W-1:0] width_reg;
    logic [COL_W-1:0] col_reg, col_next;
    logic             odd_reg, odd_next;
    rgb_t             held_reg, held_next;

    logic [CFG_W-1:0] len;
    logic [CFG_W-1:0] pairs_end;
    logic [COL_W-1:0] col_cur;
    logic             odd_cur;
    logic [CFG_W-1:0] col_inc;
    logic             accept;
    logic             in_pairs;
    rgb_t             pix;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        if (width_reg < WIDTH_MIN)
            len = WIDTH_MIN;
        else if (width_reg > WIDTH_MAX)
            len = WIDTH_MAX;
        else
            len = width_reg;
        pairs_end = {len[CFG_W-1:1], 1'b0};
    end

    always_comb
    begin
        pix.r = in_data.red_in;
        pix.g = in_data.green_in;
        pix.b = in_data.blue_in;

        // frame start restarts at column 0 of an even row
        col_cur = in_data.frame_start ? '0 : col_reg;
        odd_cur = in_data.frame_start ? 1'b0 : odd_reg;

        in_pairs = ({1'b0, col_cur} < pairs_end);
        col_inc  = {1'b0, col_cur} + CFG_W'(1);

        held_next = held_reg;
        col_next  = col_reg;
        odd_next  = odd_reg;
        push      = 1'b0;

        push_op.emit = odd_cur;
        push_op.idx  = col_cur[COL_W-1:1];
        push_op.pm   = rgb_max(held_reg, pix);

        if (accept)
        begin
            if (in_pairs && !col_cur[0])
                held_next = pix;
            push = in_pairs && col_cur[0];
            if (col_inc >= len)
            begin
                col_next = '0;
                odd_next = !odd_cur;
            end
            else
            begin
                col_next = col_inc[COL_W-1:0];
                odd_next = odd_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= WIDTH_RESET;
            col_reg   <= '0;
            odd_reg   <= 1'b0;
            held_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                width_reg <= cfg_wr_data;
            col_reg  <= col_next;
            odd_reg  <= odd_next;
            held_reg <= held_next;
        end
    end

endmodule

@@ rtl/rmp_queue.sv @@
// Short op queue between front and back ends.
// Depends on rmp_pkg and the assertion macro header.
`include "rgb_max_pool_2x2_assert.svh"

module rmp_queue
    import rmp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  op_t       push_op,
    input  logic      pop,
    output op_t       pop_op,
    output q_status_t status
);

    op_t            slot_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] count_reg, count_next;

    assign status.full  = (count_reg == QCW'(QDEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_op       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QAW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QAW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + QCW'(1);
        else if (pop && !push)
            count_next = count_reg - QCW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_op;
    end

    `RMP_ASSERT_ALWAYS(a_count_bound, count_reg <= QCW'(QDEPTH), "queue count beyond depth")
    `RMP_ASSERT_SAME(a_no_overflow, push, !status.full || pop, "push into full queue")
    `RMP_ASSERT_SAME(a_no_underflow, pop, !status.empty, "pop from empty queue")
    `RMP_ASSERT_NEXT(a_ptr_gap, push && !pop, count_reg == $past(count_reg) + QCW'(1), "count slip")

endmodule

@@ rtl/rmp_back.sv @@
// Back end: line buffer memory, 2x2 maximum and output register.
// Depends on rmp_pkg; takes ops from rmp_queue in order.
module rmp_back
    import rmp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  q_status_t  q_status,
    input  op_t        pop_op,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output pixel_out_t out_data
);

    rgb_t       line_mem [LINE_DEPTH];
    rgb_t       rd_reg;
    logic       s1_valid_reg, s1_valid_next;
    rgb_t       s1_pm_reg;
    logic       out_valid_reg, out_valid_next;
    pixel_out_t out_data_reg;
    logic       s1_adv;
    rgb_t       res;

    // advance the read stage whenever the output register can take its item
    assign s1_adv = !out_valid_reg || out_ready;
    assign pop    = !q_status.empty && (!s1_valid_reg || s1_adv);
    assign res    = rgb_max(rd_reg, s1_pm_reg);

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (!s1_valid_reg || s1_adv)
            s1_valid_next = pop && pop_op.emit;
        if (s1_adv)
            out_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // single port: store pair maxima of even rows, read them back on odd rows
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (pop_op.emit)
            begin
                rd_reg    <= line_mem[pop_op.idx];
                s1_pm_reg <= pop_op.pm;
            end
            else
            begin
                line_mem[pop_op.idx] <= pop_op.pm;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_valid_reg)
        begin
            out_data_reg.red_out   <= res.r;
            out_data_reg.green_out <= res.g;
            out_data_reg.blue_out  <= res.b;
            out_data_reg.alpha_out <= ALPHA_VALUE;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ rtl/rgb_max_pool_2x2.sv @@
// 2x2 stride-2 max pooling on an RGB pixel stream, one pixel per cycle.
// Path: each emitting op passes the op queue, the line buffer read stage and the output register.
// Throughput: one pixel per cycle; the line buffer takes one op per pixel pair, so only a
// stalled output, once the op queue is full, holds off the input.
// Reset: position, queue and pipeline valids clear, width returns to 640.
// The line buffer is not cleared; an odd row reads what the last even row stored.
module rgb_max_pool_2x2
    import rmp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  pixel_in_t        in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output pixel_out_t       out_data
);

    q_status_t q_status;
    logic      push;
    op_t       push_op;
    logic      pop;
    op_t       pop_op;

    rmp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .q_status    (q_status),
        .push        (push),
        .push_op     (push_op)
    );

    rmp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .pop_op  (pop_op),
        .status  (q_status)
    );

    rmp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .pop_op    (pop_op),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
